// File: sv/integer_to_radix_ascii_core_macros.svh
// Assertion macros shared by the integer to radix text core.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/itoa_pkg.sv
// Shared constants, types and the digit lookup of the integer to radix text core.
package itoa_pkg;

	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned RADIX_W    = 5;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int unsigned IDX_W      = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	// divider: DIV_STEPS quotient bits per cycle
	localparam int unsigned DIV_STEPS    = 8;
	localparam int unsigned DIV_CYCLES   = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int unsigned DIV_PAD_BITS = DIV_CYCLES * DIV_STEPS;
	localparam int unsigned DIV_CNT_W    = $clog2(DIV_CYCLES + 1);

	// job queue between front and back; depth must be a power of two
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
		logic [RADIX_W-1:0]    base;
	} itoa_job_t;

	typedef struct packed {
		logic      valid;
		itoa_job_t job;
	} itoa_job_beat_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [RADIX_W-1:0]    divisor;
	} itoa_div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [DIGIT_W-1:0]    remainder;
	} itoa_div_rsp_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_DIGITS
	} itoa_back_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

// File: sv/itoa_if.sv
// Valid/ready channel interfaces: value in, characters out, radix writes.
interface itoa_value_if import itoa_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itoa_char_if import itoa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface itoa_cfg_if import itoa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [RADIX_W-1:0] radix;

	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface

// File: sv/itoa_front.sv
// Front end: radix register, value intake, sign split and base clamp.
module itoa_front import itoa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	itoa_value_if.sink     operand,
	itoa_cfg_if.sink       cfg,
	input  logic           q_full,
	output itoa_job_beat_t push
);

	logic [RADIX_W-1:0]    radix_q;
	logic                  neg;
	logic [VALUE_BITS-1:0] raw;
	logic [RADIX_W-1:0]    base;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg.valid && cfg.ready) begin
			radix_q <= cfg.radix;
		end
	end

	assign operand.ready = !q_full;

	// magnitude as unsigned, so the most negative value stays exact
	assign raw  = operand.value;
	assign neg  = raw[VALUE_BITS-1];

	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	assign push.valid    = operand.valid && operand.ready;
	assign push.job.neg  = neg;
	assign push.job.mag  = neg ? (~raw + VALUE_BITS'(1)) : raw;
	assign push.job.base = base;

endmodule

// File: sv/itoa_queue.sv
// Short job queue between the front and back ends.
`include "integer_to_radix_ascii_core_macros.svh"

module itoa_queue import itoa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  itoa_job_beat_t push,
	output logic           full,
	input  logic           pop,
	output itoa_job_beat_t head
);

	itoa_job_t         mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ITOA_ASSERT_NOW(a_q_no_overflow, clk, arst_n, push.valid, !full, "push into full queue")
	`ITOA_ASSERT_NOW(a_q_no_underflow, clk, arst_n, pop, head.valid, "pop from empty queue")
	`ITOA_ASSERT_NOW(a_q_count_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: sv/itoa_div.sv
// Small-divisor restoring divider, DIV_STEPS quotient bits per cycle.
module itoa_div import itoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  itoa_div_req_t req,
	output itoa_div_rsp_t rsp
);

	logic [DIV_PAD_BITS-1:0] work_q;
	logic [DIV_PAD_BITS-1:0] work_d;
	logic [DIGIT_W-1:0]      rem_q;
	logic [DIGIT_W-1:0]      rem_d;
	logic [RADIX_W-1:0]      divisor_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIGIT_W:0]        trial;

	// remainder stays below the divisor (at most 16), so a trial fits DIGIT_W+1 bits
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial  = {rem_d, work_d[DIV_PAD_BITS-1]};
			work_d = {work_d[DIV_PAD_BITS-2:0], 1'b0};
			if (trial >= divisor_q) begin
				rem_d     = DIGIT_W'(trial - divisor_q);
				work_d[0] = 1'b1;
			end else begin
				rem_d = trial[DIGIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= DIV_PAD_BITS'(req.dividend);
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = work_q[VALUE_BITS-1:0];
	assign rsp.remainder = rem_q;

endmodule

// File: sv/itoa_back.sv
// Back end: digit loop over the divider, digit store and character output register.
`include "integer_to_radix_ascii_core_macros.svh"

module itoa_back import itoa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  itoa_job_beat_t head,
	output logic           pop,
	output itoa_div_req_t  div_req,
	input  itoa_div_rsp_t  div_rsp,
	itoa_char_if.source    text
);

	itoa_back_state_t      state_q;
	itoa_back_state_t      state_d;
	logic [DIGIT_W-1:0]    store_q [VALUE_BITS];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  neg_q;
	logic [RADIX_W-1:0]    base_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;
	logic                  out_valid_q;

	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      rd_sel;
	logic                  more;
	logic                  out_free;
	logic                  load_out;
	logic [CHAR_W-1:0]     char_d;
	logic                  last_d;

	assign cnt_inc  = count_q + CNT_W'(1);
	assign rd_sel   = rd_idx_q - CNT_W'(1);
	assign more     = (div_rsp.quotient != '0) && (cnt_inc < CNT_W'(VALUE_BITS));
	assign out_free = !out_valid_q || text.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_rsp.done && !more) begin
					state_d = neg_q ? BK_SIGN : BK_DIGITS;
				end
			end
			BK_SIGN: begin
				if (out_free) begin
					state_d = BK_DIGITS;
				end
			end
			BK_DIGITS: begin
				if (out_free && rd_idx_q == CNT_W'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = head.job.mag;
		div_req.divisor  = head.job.base;
		load_out         = 1'b0;
		char_d           = digit_char(store_q[rd_sel[IDX_W-1:0]]);
		last_d           = (rd_idx_q == CNT_W'(1));
		unique case (state_q)
			BK_IDLE: begin
				pop           = head.valid;
				div_req.start = head.valid;
			end
			BK_DIV: begin
				div_req.start    = div_rsp.done && more;
				div_req.dividend = div_rsp.quotient;
				div_req.divisor  = base_q;
			end
			BK_SIGN: begin
				load_out = out_free;
				char_d   = ASCII_MINUS;
				last_d   = 1'b0;
			end
			BK_DIGITS: begin
				load_out = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DIV && div_rsp.done) begin
			store_q[count_q[IDX_W-1:0]] <= div_rsp.remainder;
		end
		if (load_out) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			neg_q       <= 1'b0;
			base_q      <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				neg_q   <= head.job.neg;
				base_q  <= head.job.base;
				count_q <= '0;
			end
			if (state_q == BK_DIV && div_rsp.done) begin
				count_q <= cnt_inc;
				if (!more) begin
					rd_idx_q <= cnt_inc;
				end
			end
			if (state_q == BK_DIGITS && load_out) begin
				rd_idx_q <= rd_sel;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

	`ITOA_ASSERT_NOW(a_bk_rd_in_range, clk, arst_n, state_q == BK_DIGITS, (rd_idx_q != '0) && (rd_idx_q <= count_q), "digit read outside stored digits")
	`ITOA_ASSERT_NEXT(a_bk_last_ends_job, clk, arst_n, load_out && last_d, state_q == BK_IDLE, "final character did not end the job")
	`ITOA_ASSERT_NOW(a_bk_div_free, clk, arst_n, div_req.start, !div_rsp.busy, "divider started while busy")

endmodule

// File: sv/integer_to_radix_ascii_core.sv
// Top level of the signed integer to radix text converter.
//
// Takes one signed 32-bit value per beat on operand and sends its text in the
// base held by the radix register, one ASCII character per beat on text, most
// significant first: a leading '-' for a negative value, then lower-case digits
// 0-9 and a-f. The final character of each value carries last; there is no
// terminator. Zero gives a single '0', and the most negative value is handled
// exactly through its unsigned magnitude. A radix below 2 acts as 2 and one
// above 16 acts as 16; reset leaves it at 10. Write the radix only while the
// block is idle. The front end classifies each value and drops it into a
// two-deep job queue, so up to two further values are taken while one is being
// converted. The back end runs a shared divider that yields eight quotient bits
// a cycle, running it anew for each digit, and each character then leaves
// through the output register. The output register lets the next value start
// its divisions while the final character of the previous one waits to be taken.
module integer_to_radix_ascii_core import itoa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	itoa_value_if.sink  operand,
	itoa_char_if.source text,
	itoa_cfg_if.sink    cfg
);

	// front to queue
	itoa_job_beat_t push;
	logic           q_full;

	// queue to back
	itoa_job_beat_t head;
	logic           pop;

	// back to divider
	itoa_div_req_t  div_req;
	itoa_div_rsp_t  div_rsp;

	// intake: hold the radix, split sign and magnitude, clamp the base
	itoa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.cfg     (cfg),
		.q_full  (q_full),
		.push    (push)
	);

	// decouple intake from conversion
	itoa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// shared divider: one digit per run
	itoa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// digit loop, digit store and character output
	itoa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.text    (text)
	);

endmodule

// File: tb/sv/tb_integer_to_radix_ascii_core.sv
// Self-checking testbench for the integer to radix text core.
module tb_integer_to_radix_ascii_core import itoa_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// Glyphs for digit values 0 to 15, first glyph in the top byte.
	localparam logic [8*16-1:0]       DIGIT_GLYPHS = "0123456789abcdef";
	localparam logic [CHAR_W-1:0]     MINUS_CHAR   = "-";
	localparam logic [VALUE_BITS-1:0] MAX_VALUE    = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] MIN_VALUE    = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam int REPORT_LIMIT   = 10;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_PHASES  = 6;
	localparam int ITEMS_PER_PHASE = 21;

	// Patterns the character receiver cycles through.
	typedef enum int {
		SINK_FREE,
		SINK_MOSTLY_READY,
		SINK_MOSTLY_STALLED,
		SINK_ALTERNATE
	} sink_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} char_beat_t;

	// One row of directed stimulus; an empty string means "ask the predictor".
	typedef struct {
		logic [RADIX_W-1:0]    radix;
		logic [VALUE_BITS-1:0] value;
		string                 text;
	} text_row_t;

	logic clk;
	logic arst_n;

	itoa_value_if operand_if();
	itoa_char_if  text_if();
	itoa_cfg_if   cfg_if();

	integer_to_radix_ascii_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_if),
		.text    (text_if),
		.cfg     (cfg_if)
	);

	// Characters still owed by the block, oldest first.
	char_beat_t            pending_chars[$];
	// Our own copy of the radix register.
	logic [RADIX_W-1:0]    radix_shadow = RADIX_RESET;
	int                    error_count  = 0;
	// Index of the random phase under way; -1 during the directed part.
	int                    rand_phase   = -1;
	int                    burst_left   = 0;

	// Directed rows: zero, the signed extremes, every clamp of the radix and
	// a few ordinary values. Strings are typed only where they are obvious.
	text_row_t directed_rows[25] = '{
		'{5'd10, 32'd0,          "0"},
		'{5'd10, 32'd7,          "7"},
		'{5'd10, -32'sd1,        "-1"},
		'{5'd10, 32'h7fff_ffff,  "2147483647"},
		'{5'd10, 32'h8000_0000,  "-2147483648"},
		'{5'd10, 32'd1234567890, ""},
		'{5'd10, -32'sd905,      "-905"},
		'{5'd16, 32'h7fff_ffff,  "7fffffff"},
		'{5'd16, 32'h8000_0000,  "-80000000"},
		'{5'd16, 32'hdead_beef,  ""},
		'{5'd16, 32'h00ab_cdef,  "abcdef"},
		'{5'd2,  32'd0,          "0"},
		'{5'd2,  32'd5,          "101"},
		'{5'd2,  -32'sd1,        "-1"},
		'{5'd2,  32'h8000_0000,  ""},
		'{5'd2,  32'h7fff_ffff,  ""},
		'{5'd0,  32'd5,          "101"},
		'{5'd1,  -32'sd6,        "-110"},
		'{5'd17, 32'd255,        "ff"},
		'{5'd31, -32'sd4096,     "-1000"},
		'{5'd31, 32'h7fff_ffff,  "7fffffff"},
		'{5'd3,  32'h8000_0000,  ""},
		'{5'd7,  32'd48,         "66"},
		'{5'd9,  32'd81,         "100"},
		'{5'd8,  -32'sd8,        "-10"}
	};

	// Free-running clock, 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the text of one value in the current radix and queue its beats.
	// Clamp the radix to 2..16, convert through the unsigned magnitude so the
	// most negative value comes out exact, and always emit at least one digit.
	function automatic void queue_radix_text(input logic [VALUE_BITS-1:0] word);
		logic [VALUE_BITS-1:0] mag;
		logic [VALUE_BITS-1:0] base;
		logic [DIGIT_W-1:0]    digits [VALUE_BITS];
		int                    n;
		base = VALUE_BITS'(radix_shadow);
		if (radix_shadow < RADIX_MIN) base = VALUE_BITS'(RADIX_MIN);
		if (radix_shadow > RADIX_MAX) base = VALUE_BITS'(RADIX_MAX);
		mag = word[VALUE_BITS-1] ? ('0 - word) : word;
		n = 0;
		do begin
			digits[n] = DIGIT_W'(mag % base);
			mag = mag / base;
			n++;
		end while (mag != '0 && n < VALUE_BITS);
		if (word[VALUE_BITS-1])
			pending_chars.push_back('{MINUS_CHAR, 1'b0});
		for (int k = n - 1; k >= 0; k--)
			pending_chars.push_back('{DIGIT_GLYPHS[8*(15-digits[k]) +: 8], k == 0});
	endfunction

	// Queue a hand-typed string, last set on its final character.
	function automatic void queue_typed_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back('{s[i], i == s.len() - 1});
	endfunction

	// Compare one received character beat with the oldest one owed.
	function automatic void check_char(input logic [CHAR_W-1:0] ch, input logic lst);
		char_beat_t want;
		if (pending_chars.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("unexpected character beat: char %h last %b", ch, lst);
		end else begin
			want = pending_chars.pop_front();
			if (want.character !== ch || want.last !== lst) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("character mismatch: expected char %h last %b, got char %h last %b",
						want.character, want.last, ch, lst);
			end
		end
	endfunction

	// Draw a value: mostly short texts and the edges of the range, with some
	// full-width noise so every bit of the word toggles.
	function automatic logic [VALUE_BITS-1:0] draw_value();
		logic [VALUE_BITS-1:0] w;
		case ($urandom_range(0, 5))
			0: w = VALUE_BITS'($urandom);
			1: w = VALUE_BITS'($urandom_range(0, 40));
			2: w = '0 - VALUE_BITS'($urandom_range(1, 40));
			3: w = $urandom_range(0, 1) ? MAX_VALUE - VALUE_BITS'($urandom_range(0, 3))
			                            : MIN_VALUE + VALUE_BITS'($urandom_range(0, 3));
			4: begin
				w = VALUE_BITS'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
				if ($urandom_range(0, 1) == 1) w = '0 - w;
			end
			default: begin
				w = VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
				if ($urandom_range(0, 1) == 1) w = '0 - w;
			end
		endcase
		return w;
	endfunction

	// Offer one value and hold it until the block takes the beat, then note
	// its text. Between bursts usually drop valid for a random gap; within a burst
	// leave valid high so the next value follows back to back.
	task automatic offer_value(input logic [VALUE_BITS-1:0] word, input string typed);
		int gap;
		operand_if.valid <= 1'b1;
		operand_if.value <= word;
		do @(posedge clk); while (!operand_if.ready);
		if (typed.len() != 0)
			queue_typed_text(typed);
		else
			queue_radix_text(word);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				operand_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every owed character has arrived. Each
	// value gives at least one character, so the block is idle after that.
	task automatic let_block_settle();
		operand_if.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the radix register; only ever called with the block idle.
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		cfg_if.valid <= 1'b1;
		cfg_if.radix <= r;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		radix_shadow = r;
	endtask

	// Sender side: reset, the directed table, then random phases each with a
	// radix of its own, then the final drain and verdict.
	initial begin : value_sender
		logic [RADIX_W-1:0] phase_radix [RANDOM_PHASES];
		arst_n           <= 1'b0;
		operand_if.valid <= 1'b0;
		operand_if.value <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.radix     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the table; reprogram the radix only where a row asks for a new
		// one, and only once the block has drained.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].radix != radix_shadow) begin
				let_block_settle();
				write_radix(directed_rows[i].radix);
			end
			offer_value(directed_rows[i].value, directed_rows[i].text);
		end

		// Random phases: valid extremes, an ordinary radix, a clamped extreme and random picks.
		phase_radix[0] = 5'd16;
		phase_radix[1] = 5'd2;
		phase_radix[2] = RADIX_W'($urandom_range(3, 15));
		phase_radix[3] = 5'd10;
		phase_radix[4] = RADIX_W'($urandom_range(0, 31));
		phase_radix[5] = 5'd31;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			let_block_settle();
			write_radix(phase_radix[p]);
			rand_phase = p;
			repeat (ITEMS_PER_PHASE) offer_value(draw_value(), "");
		end

		// Drain, then give any stray beat time to show up.
		let_block_settle();
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver side: check each accepted beat, then choose ready for the next
	// cycle. Once, at the start of the second random phase, hold ready low for a
	// long stretch so the job queue fills and the block pushes back on its input.
	initial begin : char_receiver
		sink_mode_t mode;
		int         mode_left;
		int         hold_left;
		bit         hold_done;
		mode      = SINK_FREE;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		text_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && text_if.valid && text_if.ready)
				check_char(text_if.character, text_if.last);
			if (!hold_done && rand_phase == 1) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode      = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				text_if.ready <= 1'b0;
			end else begin
				case (mode)
					SINK_FREE:           text_if.ready <= 1'b1;
					SINK_MOSTLY_READY:   text_if.ready <= ($urandom_range(0, 3) != 0);
					SINK_MOSTLY_STALLED: text_if.ready <= ($urandom_range(0, 3) == 0);
					default:             text_if.ready <= ~text_if.ready;
				endcase
			end
		end
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
